### design/pat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the point affine transform pipeline.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int WIDE_W  = SUM_W + 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [COEF_W-1:0] COEF_RESET = 24'sh010000;

    localparam int REFLECT_NEG_Y = 0;
    localparam int REFLECT_NEG_X = 1;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = (WIDE_W'(1) <<< (COORD_W - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -(WIDE_W'(1) <<< (COORD_W - 1));

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_SCALE     = 2'd1,
        OP_ROTATE    = 2'd2,
        OP_REFLECT   = 2'd3
    } pat_op_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP_MODE      = 4'd0,
        CFG_COEF_A       = 4'd1,
        CFG_COEF_B       = 4'd2,
        CFG_PIVOT_X      = 4'd3,
        CFG_PIVOT_Y      = 4'd4,
        CFG_DELTA_X      = 4'd5,
        CFG_DELTA_Y      = 4'd6,
        CFG_REFLECT_AXES = 4'd7
    } pat_cfg_idx_e;

    typedef struct packed {
        pat_op_e                     op_mode;
        logic signed [COEF_W-1:0]    coef_a;
        logic signed [COEF_W-1:0]    coef_b;
        logic signed [COORD_W-1:0]   pivot_x;
        logic signed [COORD_W-1:0]   pivot_y;
        logic signed [COORD_W-1:0]   delta_x;
        logic signed [COORD_W-1:0]   delta_y;
        logic [1:0]                  reflect_axes;
    } pat_cfg_t;

    typedef struct packed {
        pat_op_e                    op;
        logic signed [DIFF_W-1:0]   dx;
        logic signed [DIFF_W-1:0]   dy;
        logic signed [DIFF_W-1:0]   direct_x;
        logic signed [DIFF_W-1:0]   direct_y;
        logic                       last;
    } pat_s1_t;

    typedef struct packed {
        pat_op_e                    op;
        logic signed [PROD_W-1:0]   p_xa;
        logic signed [PROD_W-1:0]   p_yb;
        logic signed [PROD_W-1:0]   p_ya;
        logic signed [PROD_W-1:0]   p_xb;
        logic signed [DIFF_W-1:0]   direct_x;
        logic signed [DIFF_W-1:0]   direct_y;
        logic                       last;
    } pat_s2_t;

    typedef struct packed {
        pat_op_e                    op;
        logic signed [SUM_W-1:0]    sum_x;
        logic signed [SUM_W-1:0]    sum_y;
        logic signed [DIFF_W-1:0]   direct_x;
        logic signed [DIFF_W-1:0]   direct_y;
        logic                       last;
    } pat_s3_t;

endpackage

### design/pat_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module pat_cfg_regs
    import pat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output pat_cfg_t               cfg
);

    pat_cfg_t cfg_reg;
    pat_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OP_MODE:      cfg_next.op_mode      = pat_op_e'(cfg_data[1:0]);
                CFG_COEF_A:       cfg_next.coef_a       = $signed(cfg_data[COEF_W-1:0]);
                CFG_COEF_B:       cfg_next.coef_b       = $signed(cfg_data[COEF_W-1:0]);
                CFG_PIVOT_X:      cfg_next.pivot_x      = $signed(cfg_data[COORD_W-1:0]);
                CFG_PIVOT_Y:      cfg_next.pivot_y      = $signed(cfg_data[COORD_W-1:0]);
                CFG_DELTA_X:      cfg_next.delta_x      = $signed(cfg_data[COORD_W-1:0]);
                CFG_DELTA_Y:      cfg_next.delta_y      = $signed(cfg_data[COORD_W-1:0]);
                CFG_REFLECT_AXES: cfg_next.reflect_axes = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode      <= OP_TRANSLATE;
            cfg_reg.coef_a       <= COEF_RESET;
            cfg_reg.coef_b       <= COEF_RESET;
            cfg_reg.pivot_x      <= '0;
            cfg_reg.pivot_y      <= '0;
            cfg_reg.delta_x      <= '0;
            cfg_reg.delta_y      <= '0;
            cfg_reg.reflect_axes <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/pat_pre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pre
// First stage: pivot differences and the direct translate or reflect result.
// ----------------------------------------------------------------------------
module pat_pre
    import pat_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pat_cfg_t                   cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [COORD_W-1:0]  x_in,
    input  logic signed [COORD_W-1:0]  y_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pat_s1_t                    out_data
);

    logic                     valid_reg;
    pat_s1_t                  data_reg;
    pat_s1_t                  data_next;
    logic signed [DIFF_W-1:0] x_ext;
    logic signed [DIFF_W-1:0] y_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        x_ext = DIFF_W'(x_in);
        y_ext = DIFF_W'(y_in);
        data_next.op       = cfg.op_mode;
        data_next.last     = last_in;
        data_next.dx       = x_ext - DIFF_W'(cfg.pivot_x);
        data_next.dy       = y_ext - DIFF_W'(cfg.pivot_y);
        data_next.direct_x = x_ext;
        data_next.direct_y = y_ext;
        case (cfg.op_mode)
            OP_TRANSLATE:
            begin
                data_next.direct_x = x_ext + DIFF_W'(cfg.delta_x);
                data_next.direct_y = y_ext + DIFF_W'(cfg.delta_y);
            end
            OP_REFLECT:
            begin
                if (cfg.reflect_axes[REFLECT_NEG_X])
                begin
                    data_next.direct_x = -x_ext;
                end
                if (cfg.reflect_axes[REFLECT_NEG_Y])
                begin
                    data_next.direct_y = -y_ext;
                end
            end
            default:
            begin
                data_next.direct_x = x_ext;
                data_next.direct_y = y_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/pat_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_mul
// Second stage: the four difference-by-coefficient products.
// ----------------------------------------------------------------------------
module pat_mul
    import pat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pat_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  pat_s1_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pat_s2_t   out_data
);

    logic                     valid_reg;
    pat_s2_t                  data_reg;
    pat_s2_t                  data_next;
    logic signed [PROD_W-1:0] dx_w;
    logic signed [PROD_W-1:0] dy_w;
    logic signed [PROD_W-1:0] a_w;
    logic signed [PROD_W-1:0] b_w;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        dx_w = PROD_W'(in_data.dx);
        dy_w = PROD_W'(in_data.dy);
        a_w  = PROD_W'(cfg.coef_a);
        b_w  = PROD_W'(cfg.coef_b);
        data_next.op       = in_data.op;
        data_next.last     = in_data.last;
        data_next.direct_x = in_data.direct_x;
        data_next.direct_y = in_data.direct_y;
        data_next.p_xa     = dx_w * a_w;
        data_next.p_yb     = dy_w * b_w;
        data_next.p_ya     = dy_w * a_w;
        data_next.p_xb     = dx_w * b_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/pat_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_post
// Third and fourth stages: product combine with rounding, then rescale,
// pivot add, saturation and the output register.
// ----------------------------------------------------------------------------
module pat_post
    import pat_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pat_cfg_t                   cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pat_s2_t                    in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  x_out,
    output logic signed [COORD_W-1:0]  y_out,
    output logic                       overflow,
    output logic                       last_out
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic                       s3_valid_reg;
    logic                       s3_ready;
    pat_s3_t                    s3_reg;
    pat_s3_t                    s3_next;

    logic                       s4_valid_reg;
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [COORD_W-1:0]  x_next;
    logic signed [COORD_W-1:0]  y_reg;
    logic signed [COORD_W-1:0]  y_next;
    logic                       ov_reg;
    logic                       ov_next;
    logic                       last_reg;

    logic signed [SUM_W-1:0]    shift_x;
    logic signed [SUM_W-1:0]    shift_y;
    logic signed [WIDE_W-1:0]   wide_x;
    logic signed [WIDE_W-1:0]   wide_y;
    logic                       ov_x;
    logic                       ov_y;

    assign s3_ready  = !s4_valid_reg || out_ready;
    assign in_ready  = !s3_valid_reg || s3_ready;
    assign out_valid = s4_valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign overflow  = ov_reg;
    assign last_out  = last_reg;

    always_comb
    begin
        s3_next.op       = in_data.op;
        s3_next.last     = in_data.last;
        s3_next.direct_x = in_data.direct_x;
        s3_next.direct_y = in_data.direct_y;
        case (in_data.op)
            OP_SCALE:
            begin
                s3_next.sum_x = SUM_W'(in_data.p_xa) + ROUND_HALF;
                s3_next.sum_y = SUM_W'(in_data.p_yb) + ROUND_HALF;
            end
            OP_ROTATE:
            begin
                s3_next.sum_x = SUM_W'(in_data.p_xa) - SUM_W'(in_data.p_yb) + ROUND_HALF;
                s3_next.sum_y = SUM_W'(in_data.p_ya) + SUM_W'(in_data.p_xb) + ROUND_HALF;
            end
            default:
            begin
                s3_next.sum_x = '0;
                s3_next.sum_y = '0;
            end
        endcase
    end

    always_comb
    begin
        shift_x = s3_reg.sum_x >>> COEF_FRAC_BITS;
        shift_y = s3_reg.sum_y >>> COEF_FRAC_BITS;
        if (s3_reg.op == OP_SCALE || s3_reg.op == OP_ROTATE)
        begin
            wide_x = WIDE_W'(shift_x) + WIDE_W'(cfg.pivot_x);
            wide_y = WIDE_W'(shift_y) + WIDE_W'(cfg.pivot_y);
        end
        else
        begin
            wide_x = WIDE_W'(s3_reg.direct_x);
            wide_y = WIDE_W'(s3_reg.direct_y);
        end

        ov_x   = 1'b1;
        x_next = wide_x[COORD_W-1:0];
        if (wide_x > SAT_MAX)
        begin
            x_next = SAT_MAX[COORD_W-1:0];
        end
        else if (wide_x < SAT_MIN)
        begin
            x_next = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            ov_x = 1'b0;
        end

        ov_y   = 1'b1;
        y_next = wide_y[COORD_W-1:0];
        if (wide_y > SAT_MAX)
        begin
            y_next = SAT_MAX[COORD_W-1:0];
        end
        else if (wide_y < SAT_MIN)
        begin
            y_next = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            ov_y = 1'b0;
        end

        ov_next = ov_x || ov_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s3_valid_reg && s3_ready)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ov_reg   <= ov_next;
            last_reg <= s3_reg.last;
        end
    end

endmodule

### design/point_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_affine_transform
// Streaming 2D affine transform of polyline vertices.
// ----------------------------------------------------------------------------
// Vertices enter on the s_t* channel and leave on the m_t* channel, one result
// for every input transfer, in order. The frame mark rides on tlast unchanged,
// and m_tuser flags a result in which either coordinate saturated.
// The cfg_* channel writes one register per transfer and is always ready; the
// user must write it only while no vertex is in flight, which the block itself
// does not enforce. The datapath is four register stages: pivot difference,
// multiply, combine with rounding, then rescale, pivot add and saturation into
// the output register. One vertex is taken every cycle while the output is
// drained.
// Each stage has its own valid bit and holds its data while the stage after
// it is full, so a stalled receiver fills the pipeline before s_tready drops,
// and nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: translate by
// zero, unit coefficients, zero pivot and no reflection.
// ----------------------------------------------------------------------------
module point_affine_transform
    import pat_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,    // x_in [31:0], y_in [63:32]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,    // x_out [31:0], y_out [63:32]
    output logic                   m_tuser,    // overflow [0]
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pat_cfg_t                  cfg;
    logic                      s1_valid;
    logic                      s1_ready;
    pat_s1_t                   s1_data;
    logic                      s2_valid;
    logic                      s2_ready;
    pat_s2_t                   s2_data;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;

    pat_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pat_pre u_pre
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_in      ($signed(s_tdata[COORD_W-1:0])),
        .y_in      ($signed(s_tdata[2*COORD_W-1:COORD_W])),
        .last_in   (s_tlast),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    pat_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    pat_post #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_out     (x_out),
        .y_out     (y_out),
        .overflow  (m_tuser),
        .last_out  (m_tlast)
    );

    assign m_tdata = {y_out, x_out};

endmodule

### design/pat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_checker
// Port-level checks for the point affine transform, bound to the top level.
// ----------------------------------------------------------------------------
module pat_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser
);

    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A result that waits for the receiver stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Every result belongs to a vertex that was taken earlier.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result without a pending vertex");

    // The pipeline never holds more vertices than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more vertices in flight than pipeline stages");

    // A flagged result carries a clamped coordinate.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
            (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000))
        else $error("overflow flagged without a saturated coordinate");

endmodule

bind point_affine_transform pat_checker u_pat_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/point_affine_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_affine_transform_tb
// Self-checking testbench for the streaming 2D point affine transform.
// ----------------------------------------------------------------------------
// A driver feeds vertices from a queue onto the input stream, and a monitor
// drains the output stream. Both sides idle at random. Each accepted vertex is
// run through a predictor that holds its own copy of the registers, and every
// result is compared field by field with the oldest prediction. A short
// directed part covers reset defaults, every operation, rounding halves,
// saturation, negation of the most negative value and extreme coefficients.
// A random part then walks through many register settings with polylines of
// random content. Registers are only written while no vertex is in flight.
// ----------------------------------------------------------------------------
module point_affine_transform_tb;
    import pat_pkg::*;

    localparam int COEF_FRAC = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd8;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;

    localparam logic [COEF_W-1:0] COEF_HALF = 24'h00_8000;
    localparam logic [COEF_W-1:0] COEF_TWO = 24'h02_0000;
    localparam logic [COEF_W-1:0] COEF_COS45 = 24'h00_B505;
    localparam logic [COEF_W-1:0] COEF_MAX = 24'h7F_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 24'h80_0000;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } vertex_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               ov;
        logic               last;
    } point_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;    // x_in [31:0], y_in [63:32]
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;         // x_out [31:0], y_out [63:32]
    logic                  m_tuser;         // overflow [0]
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pat_cfg_t   cfg_model;
    vertex_t    pending_vertices[$];
    point_t     expected_points[$];
    reg_write_t reg_writes[$];
    vertex_t    held_vertex;

    int vertices_queued = 0;
    int points_checked = 0;
    int points_saturated = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int send_gap = 0;
    int send_stretch = 0;
    bit send_calm = 1'b0;
    int recv_gap = 0;
    int recv_stretch = 0;
    bit recv_calm = 1'b0;

    point_affine_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint round_q(longint p);
        return (p + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v, inout logic ov);
        if (v > longint'($signed(COORD_MAX)))
        begin
            ov = 1'b1;
            return COORD_MAX;
        end
        if (v < longint'($signed(COORD_MIN)))
        begin
            ov = 1'b1;
            return COORD_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t transform_point(pat_cfg_t c, vertex_t v);
        longint x, y, px, py, a, b, dx, dy, rx, ry;
        point_t r;
        x = $signed(v.x);
        y = $signed(v.y);
        px = $signed(c.pivot_x);
        py = $signed(c.pivot_y);
        a = $signed(c.coef_a);
        b = $signed(c.coef_b);
        dx = x - px;
        dy = y - py;
        rx = x;
        ry = y;
        case (c.op_mode)
            OP_TRANSLATE:
            begin
                rx = x + longint'($signed(c.delta_x));
                ry = y + longint'($signed(c.delta_y));
            end
            OP_SCALE:
            begin
                rx = px + round_q(dx * a);
                ry = py + round_q(dy * b);
            end
            OP_ROTATE:
            begin
                rx = px + round_q(dx * a - dy * b);
                ry = py + round_q(dy * a + dx * b);
            end
            default:
            begin
                if (c.reflect_axes[REFLECT_NEG_Y])
                    ry = -y;
                if (c.reflect_axes[REFLECT_NEG_X])
                    rx = -x;
            end
        endcase
        r.ov = 1'b0;
        r.x = clamp_coord(rx, r.ov);
        r.y = clamp_coord(ry, r.ov);
        r.last = v.last;
        return r;
    endfunction

    function automatic void update_model(reg_write_t w);
        case (w.index)
            CFG_OP_MODE:      cfg_model.op_mode = pat_op_e'(w.data[1:0]);
            CFG_COEF_A:       cfg_model.coef_a = w.data[COEF_W-1:0];
            CFG_COEF_B:       cfg_model.coef_b = w.data[COEF_W-1:0];
            CFG_PIVOT_X:      cfg_model.pivot_x = w.data;
            CFG_PIVOT_Y:      cfg_model.pivot_y = w.data;
            CFG_DELTA_X:      cfg_model.delta_x = w.data;
            CFG_DELTA_Y:      cfg_model.delta_y = w.data;
            CFG_REFLECT_AXES: cfg_model.reflect_axes = w.data[1:0];
            default:          ;
        endcase
    endfunction

    function automatic int draw_wait(inout int stretch, inout bit calm);
        if (stretch == 0)
        begin
            stretch = $urandom_range(8, 64);
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:
            case ($urandom_range(0, 3))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
            1, 2:    return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] c;
        case ($urandom_range(0, 4))
            0:
            case ($urandom_range(0, 2))
                0:       return COEF_MAX;
                1:       return COEF_MIN;
                default: return '0;
            endcase
            1, 2:
            begin
                c = COEF_RESET + 24'($urandom_range(0, 24'h02_0000)) - 24'h01_0000;
                return ($urandom_range(0, 1) == 1) ? -c : c;
            end
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (after %0d checked)",
                 what, got, want, points_checked);
        mismatches++;
    endtask

    task automatic queue_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.last = last;
        pending_vertices.insert(pending_vertices.size(), v);
        vertices_queued++;
    endtask

    task automatic queue_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data = data;
        reg_writes.insert(reg_writes.size(), w);
    endtask

    // Valid stays high across back-to-back writes and drops after the last one.
    task automatic flush_register_writes();
        reg_write_t w;
        while (reg_writes.size() > 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data <= w.data;
            do
                @(posedge clk);
            while (!cfg_ready);
            update_model(w);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic wait_idle();
        while (points_checked != vertices_queued)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_points.insert(expected_points.size(),
                                       transform_point(cfg_model, held_vertex));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_vertices.size() > 0)
                begin
                    held_vertex = pending_vertices.pop_front();
                    s_tdata <= {held_vertex.y, held_vertex.x};
                    s_tlast <= held_vertex.last;
                    s_tvalid <= 1'b1;
                    send_gap = draw_wait(send_stretch, send_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch("result without a pending vertex", m_tdata[31:0], '0);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (m_tdata[31:0] !== want.x)
                        report_mismatch("x_out", m_tdata[31:0], want.x);
                    if (m_tdata[63:32] !== want.y)
                        report_mismatch("y_out", m_tdata[63:32], want.y);
                    if (m_tuser !== want.ov)
                        report_mismatch("overflow", 32'(m_tuser), 32'(want.ov));
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", 32'(m_tlast), 32'(want.last));
                    if (want.ov)
                        points_saturated++;
                    points_checked++;
                end
                recv_gap = draw_wait(recv_stretch, recv_calm);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d of %0d vertices checked.", points_checked, vertices_queued);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int random_sent;
        int run_len;
        int phase_len;
        cfg_model.op_mode = OP_TRANSLATE;
        cfg_model.coef_a = COEF_RESET;
        cfg_model.coef_b = COEF_RESET;
        cfg_model.pivot_x = '0;
        cfg_model.pivot_y = '0;
        cfg_model.delta_x = '0;
        cfg_model.delta_y = '0;
        cfg_model.reflect_axes = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults straight out of reset.
        queue_vertex(COORD_MAX, COORD_MIN, 1'b1);
        queue_vertex(32'h1234_5678, '1, 1'b0);

        // Translation by the extreme offsets, saturating both ways.
        wait_idle();
        queue_write(CFG_DELTA_X, COORD_MAX);
        queue_write(CFG_DELTA_Y, COORD_MIN);
        flush_register_writes();
        queue_vertex(COORD_MAX, COORD_MIN, 1'b0);
        queue_vertex(COORD_MIN, COORD_MAX, 1'b1);

        // Uniform scaling by two about an off-origin pivot.
        wait_idle();
        queue_write(CFG_OP_MODE, 32'(OP_SCALE));
        queue_write(CFG_COEF_A, 32'(COEF_TWO));
        queue_write(CFG_COEF_B, 32'(COEF_TWO));
        queue_write(CFG_PIVOT_X, 3 * Q_ONE);
        queue_write(CFG_PIVOT_Y, -Q_ONE);
        flush_register_writes();
        queue_vertex(5 * Q_ONE, 7 * Q_ONE, 1'b0);
        queue_vertex(COORD_MAX, COORD_MIN, 1'b1);

        // Scaling about the origin, with products landing on rounding halves.
        wait_idle();
        queue_write(CFG_PIVOT_X, '0);
        queue_write(CFG_PIVOT_Y, '0);
        queue_write(CFG_COEF_A, 32'(COEF_HALF));
        queue_write(CFG_COEF_B, 32'(-COEF_HALF));
        flush_register_writes();
        queue_vertex(32'd1, '1, 1'b0);
        queue_vertex('1, 32'd1, 1'b1);

        // Rotation by 45 degrees about a pivot.
        wait_idle();
        queue_write(CFG_OP_MODE, 32'(OP_ROTATE));
        queue_write(CFG_COEF_A, 32'(COEF_COS45));
        queue_write(CFG_COEF_B, 32'(COEF_COS45));
        queue_write(CFG_PIVOT_X, Q_ONE);
        queue_write(CFG_PIVOT_Y, 2 * Q_ONE);
        flush_register_writes();
        queue_vertex(3 * Q_ONE, 2 * Q_ONE, 1'b0);
        queue_vertex(COORD_MIN, COORD_MAX, 1'b1);

        // Extreme coefficients, saturating on the extreme vertex.
        wait_idle();
        queue_write(CFG_OP_MODE, 32'(OP_SCALE));
        queue_write(CFG_COEF_A, 32'(COEF_MIN));
        queue_write(CFG_COEF_B, 32'(COEF_MAX));
        queue_write(CFG_PIVOT_X, '0);
        queue_write(CFG_PIVOT_Y, '0);
        flush_register_writes();
        queue_vertex(Q_ONE, Q_ONE, 1'b0);
        queue_vertex(COORD_MIN, COORD_MAX, 1'b1);

        // Every reflection, each on the most negative coordinates.
        for (int axes = 0; axes < 4; axes++)
        begin
            wait_idle();
            queue_write(CFG_OP_MODE, 32'(OP_REFLECT));
            queue_write(CFG_REFLECT_AXES, 32'(axes));
            flush_register_writes();
            queue_vertex(COORD_MIN, COORD_MIN, axes[0]);
        end

        // A write beyond the register list leaves the settings alone.
        wait_idle();
        queue_write(CFG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom());
        flush_register_writes();
        queue_vertex(Q_ONE, COORD_MIN, 1'b1);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            queue_write(CFG_OP_MODE, {$urandom()} & ~32'h3 | 32'($urandom_range(0, 3)));
            queue_write(CFG_COEF_A, {8'($urandom()), rand_coef()});
            queue_write(CFG_COEF_B, {8'($urandom()), rand_coef()});
            queue_write(CFG_PIVOT_X, rand_coord());
            queue_write(CFG_PIVOT_Y, rand_coord());
            queue_write(CFG_DELTA_X, rand_coord());
            queue_write(CFG_DELTA_Y, rand_coord());
            queue_write(CFG_REFLECT_AXES, {30'($urandom()), 2'($urandom_range(0, 3))});
            if ($urandom_range(0, 3) == 0)
                queue_write(CFG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom());
            flush_register_writes();
            phase_len = $urandom_range(10, 80);
            while (phase_len > 0)
            begin
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        queue_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
                    else
                        queue_vertex(rand_coord(), rand_coord(), k == run_len - 1);
                end
                phase_len -= run_len;
                random_sent += run_len;
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (expected_points.size() != 0)
            report_mismatch("vertices left without a result", expected_points.size(), '0);

        $display("Checked %0d transformed vertices under %0d register settings.",
                 points_checked, settings_applied);
        $display("%0d of them saturated; %0d mismatches seen.", points_saturated, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
